// ===== design/fnvkbm_pkg.sv =====
// fnvkbm_pkg: constants and codes shared by the FNV-1a key bucket mapper.
// No dependencies; imported by fnv1a_key_bucket_mapper.
`timescale 1ns / 1ps

package fnvkbm_pkg;

    localparam int HASH_W   = 64;
    localparam int CFG_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 63;
    localparam int ERR_W    = 3;
    localparam int PADDR_W  = 3;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // FNV prime is 2^40 + 0x1b3: one shifted copy plus nine low multiplier bits
    localparam int              PRIME_SHIFT  = 40;
    localparam int              PRIME_LO_W   = 9;
    localparam logic [PRIME_LO_W-1:0] PRIME_LO = 9'h1b3;

    // register indexes on the configuration port
    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_BUCKET_BYTES = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_ZERO_HASH  = 3'd1,
        ERR_NO_BUCKETS = 3'd2,
        ERR_NO_SIZE    = 3'd3,
        ERR_OVERFLOW   = 3'd4
    } err_code_t;

endpackage

// ===== design/fnv1a_key_bucket_mapper.sv =====
// fnv1a_key_bucket_mapper: 64-bit FNV-1a key hash with bucket index and position.
// Depends on fnvkbm_pkg (widths, FNV constants, error codes).
//
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// key in    | in        | in_valid / in_stall  | key_byte, key_last, key_empty
// result    | out       | out_valid / out_stall| hash_out, bucket_index, bucket_offset,
//           |           |                      | error_code
// config    | in/out    | APB psel/penable     | paddr, pwdata, prdata (bucket_count, bytes)
//
// A key byte is accepted, then takes 9 shift-add steps of the
// 65-bit adder over the low prime bits (the 2^40 term is loaded at accept).
// The last byte of a key adds a check step, 64 restoring-division steps and
// 32 shift-add steps on the same 65-bit adder, and a load of the result
// register. A stalled result blocks nothing until the next key's result, which
// holds in its load cycle until the register frees. Reset sets both registers to 1.
`timescale 1ns / 1ps

module fnv1a_key_bucket_mapper (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fnvkbm_pkg::PADDR_W-1:0]    paddr,
    input  logic [fnvkbm_pkg::CFG_W-1:0]      pwdata,
    output logic [fnvkbm_pkg::CFG_W-1:0]      prdata,
    output logic                              pready,
    // key byte requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fnvkbm_pkg::BYTE_W-1:0]     key_byte,
    input  logic                              key_last,
    input  logic                              key_empty,
    // results
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fnvkbm_pkg::HASH_W-1:0]     hash_out,
    output logic [fnvkbm_pkg::CFG_W-1:0]      bucket_index,
    output logic [fnvkbm_pkg::POS_W-1:0]      bucket_offset,
    output logic [fnvkbm_pkg::ERR_W-1:0]      error_code
);
    import fnvkbm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_FIN,
        S_DIV,
        S_MUL,
        S_EMIT
    } state_t;

    localparam int CNT_W = $clog2(HASH_W);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [HASH_W-1:0]    h_reg, h_next;
    logic                 zero_reg, zero_next;
    logic                 last_reg, last_next;
    logic [HASH_W-1:0]    acc_reg, acc_next;
    logic [HASH_W-1:0]    mcand_reg, mcand_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    err_code_t            err_reg, err_next;
    logic [CFG_W-1:0]     count_reg, count_next;
    logic [CFG_W-1:0]     size_reg, size_next;
    logic                 out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]    hash_out_reg, hash_out_next;
    logic [CFG_W-1:0]     bucket_index_reg, bucket_index_next;
    logic [POS_W-1:0]     bucket_offset_reg, bucket_offset_next;
    err_code_t            error_code_reg, error_code_next;

    // shared 65-bit adder / subtractor
    logic [HASH_W-1:0]    add_a;
    logic [HASH_W-1:0]    add_b;
    logic                 add_sub;
    logic [HASH_W:0]      add_sum;

    logic                 in_accept;
    logic                 cfg_write;
    logic [HASH_W-1:0]    key_x;
    logic [CFG_W:0]       rem_shift;

    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{HASH_W{1'b0}}, add_sub};

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_BUCKET_BYTES) ? size_reg : count_reg;

    assign key_x     = h_reg ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte};
    // next partial remainder: shift in one hash bit, MSB first
    assign rem_shift = {rem_reg, h_reg[cnt_reg]};

    assign out_valid       = out_valid_reg;
    assign hash_out        = hash_out_reg;
    assign bucket_index    = bucket_index_reg;
    assign bucket_offset   = bucket_offset_reg;
    assign error_code      = error_code_reg;

    // route the shared adder
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = mcand_reg;
        add_sub = 1'b0;
        if (state_reg == S_DIV)
        begin
            add_a   = {{(HASH_W-CFG_W-1){1'b0}}, rem_shift};
            add_b   = {{(HASH_W-CFG_W){1'b0}}, count_reg};
            add_sub = 1'b1;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        cnt_next             = cnt_reg;
        h_next               = h_reg;
        zero_next            = zero_reg;
        last_next            = last_reg;
        acc_next             = acc_reg;
        mcand_next           = mcand_reg;
        rem_next             = rem_reg;
        err_next             = err_reg;
        count_next           = count_reg;
        size_next            = size_reg;
        out_valid_next       = out_valid_reg;
        hash_out_next        = hash_out_reg;
        bucket_index_next    = bucket_index_reg;
        bucket_offset_next   = bucket_offset_reg;
        error_code_next      = error_code_reg;

        // drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            if (paddr[2] == REG_BUCKET_COUNT)
            begin
                count_next = pwdata;
            end
            else
            begin
                size_next = pwdata;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    last_next = key_last;
                    if (!key_empty)
                    begin
                        // load the 2^40 term, then add the low prime bits
                        if (key_x == '0)
                        begin
                            zero_next = 1'b1;
                        end
                        acc_next   = key_x << PRIME_SHIFT;
                        mcand_next = key_x;
                        cnt_next   = '0;
                        state_next = S_HASH;
                    end
                    else if (key_last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_HASH:
            begin
                if (PRIME_LO[cnt_reg[$clog2(PRIME_LO_W)-1:0]])
                begin
                    acc_next = add_sum[HASH_W-1:0];
                end
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PRIME_LO_W - 1))
                begin
                    h_next     = acc_next;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end

            S_FIN:
            begin
                // lowest error code wins
                if (zero_reg)
                begin
                    err_next   = ERR_ZERO_HASH;
                    state_next = S_EMIT;
                end
                else if (count_reg == '0)
                begin
                    err_next   = ERR_NO_BUCKETS;
                    state_next = S_EMIT;
                end
                else if (size_reg == '0)
                begin
                    err_next   = ERR_NO_SIZE;
                    state_next = S_EMIT;
                end
                else
                begin
                    err_next   = ERR_NONE;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(HASH_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // restoring step: keep the difference when no borrow
                if (add_sum[HASH_W])
                begin
                    rem_next = add_sum[CFG_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[CFG_W-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    mcand_next = {{(HASH_W-CFG_W){1'b0}}, size_reg};
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                if (rem_reg[cnt_reg[$clog2(CFG_W)-1:0]])
                begin
                    acc_next = add_sum[HASH_W-1:0];
                end
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CFG_W - 1))
                begin
                    err_next   = acc_next[HASH_W-1] ? ERR_OVERFLOW : ERR_NONE;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    error_code_next = err_reg;
                    if (err_reg == ERR_NONE)
                    begin
                        hash_out_next        = h_reg;
                        bucket_index_next    = rem_reg;
                        bucket_offset_next   = acc_reg[POS_W-1:0];
                    end
                    else
                    begin
                        hash_out_next        = '0;
                        bucket_index_next    = '0;
                        bucket_offset_next   = '0;
                    end
                    h_next     = FNV_BASIS;
                    zero_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            h_reg          <= FNV_BASIS;
            zero_reg       <= 1'b0;
            last_reg       <= 1'b0;
            err_reg        <= ERR_NONE;
            count_reg      <= CFG_W'(1);
            size_reg       <= CFG_W'(1);
            out_valid_reg  <= 1'b0;
            error_code_reg <= ERR_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            h_reg          <= h_next;
            zero_reg       <= zero_next;
            last_reg       <= last_next;
            err_reg        <= err_next;
            count_reg      <= count_next;
            size_reg       <= size_next;
            out_valid_reg  <= out_valid_next;
            error_code_reg <= error_code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg             <= acc_next;
        mcand_reg           <= mcand_next;
        rem_reg             <= rem_next;
        hash_out_reg        <= hash_out_next;
        bucket_index_reg    <= bucket_index_next;
        bucket_offset_reg   <= bucket_offset_next;
    end

    // an errored result carries no hash, bucket or position
    a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |->
            (hash_out == '0) && (bucket_index == '0) && (bucket_offset == '0))
        else $error("errored result carries nonzero payload");

    // partial remainder stays below the divisor throughout the division
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < count_reg))
        else $error("partial remainder not below bucket count");

    // a clean result names a bucket that exists
    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code == ERR_NONE) |-> (bucket_index < count_reg))
        else $error("bucket index out of range");

    // a new result only appears from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_EMIT))
        else $error("result raised outside emit step");

endmodule

// ===== test/tb_fnv1a_key_bucket_mapper.sv =====
// tb_fnv1a_key_bucket_mapper: self-checking bench for the FNV-1a key bucket mapper.
// Depends on fnvkbm_pkg and fnv1a_key_bucket_mapper; drives key bytes and APB writes,
// predicts hash, bucket and position per key and checks every result in order.
`timescale 1ns / 1ps

module tb_fnv1a_key_bucket_mapper;

    import fnvkbm_pkg::*;

    // 64-bit FNV prime, kept here so the prediction does not lean on the RTL split
    localparam logic [HASH_W-1:0] FNV64_PRIME = 64'h0000_0100_0000_01b3;

    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = 160;      // covers one byte plus the last-byte tail
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int N_PHASES      = 6;
    localparam int N_DIR_ROWS    = 19;
    localparam int MAX_PRINTED   = 100;

    // one result as the block presents it
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [CFG_W-1:0]  bucket;
        logic [POS_W-1:0]  pos;
        err_code_t         err;
    } bucket_result_t;

    // one directed request, with an optional register load before it and an
    // optional hand-written expectation
    typedef struct packed {
        bit               set_cfg;
        logic [CFG_W-1:0] count;
        logic [CFG_W-1:0] size;
        logic [BYTE_W-1:0] kbyte;
        logic             last;
        logic             empty;
        bit               typed;
        bucket_result_t   exp;
    } key_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [CFG_W-1:0]    pwdata;
    logic [CFG_W-1:0]    prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   key_byte;
    logic                key_last;
    logic                key_empty;
    logic                out_valid;
    logic                out_stall;
    logic [HASH_W-1:0]   hash_out;
    logic [CFG_W-1:0]    bucket_index;
    logic [POS_W-1:0]    bucket_offset;
    logic [ERR_W-1:0]    error_code;

    // predictor state: running key hash, zero-after-xor flag and register copies
    logic [HASH_W-1:0]   key_hash;
    bit                  key_zero_seen;
    logic [CFG_W-1:0]    cfg_count;
    logic [CFG_W-1:0]    cfg_size;

    bucket_result_t      pending_buckets [$];
    key_row_t            dir_rows [N_DIR_ROWS];
    int                  n_mismatch;
    int                  n_cycles;
    bit                  quiet_run;

    fnv1a_key_bucket_mapper dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .key_byte        (key_byte),
        .key_last        (key_last),
        .key_empty       (key_empty),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hash_out        (hash_out),
        .bucket_index    (bucket_index),
        .bucket_offset   (bucket_offset),
        .error_code      (error_code)
    );

    always #5 clk = ~clk;

    // Bound the run; a hung handshake or a result that never comes lands here.
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Print one line per mismatch (capped) and count every one.
    task automatic note_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTED)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    // Advance the predicted key state by one request; hand back the result
    // when the request closes the key.
    task automatic fnv_bucket_step(input logic [BYTE_W-1:0] kb, input logic kl,
                                   input logic ke, output bit produced,
                                   output bucket_result_t res);
        logic [HASH_W-1:0] mixed;
        logic [HASH_W-1:0] bkt;
        logic [HASH_W-1:0] place;
        produced = 1'b0;
        res = '0;
        // empty requests leave the running hash untouched
        if (!ke)
        begin
            mixed = key_hash ^ {{(HASH_W-BYTE_W){1'b0}}, kb};
            if (mixed == '0)
                key_zero_seen = 1'b1;
            key_hash = mixed * FNV64_PRIME;
        end
        if (kl)
        begin
            produced = 1'b1;
            // lowest error code wins; every error zeroes the data fields
            if (key_zero_seen)
                res.err = ERR_ZERO_HASH;
            else if (cfg_count == '0)
                res.err = ERR_NO_BUCKETS;
            else if (cfg_size == '0)
                res.err = ERR_NO_SIZE;
            else
            begin
                bkt   = key_hash % {32'd0, cfg_count};
                place = {32'd0, bkt[CFG_W-1:0]} * {32'd0, cfg_size};
                if (place[HASH_W-1])
                    res.err = ERR_OVERFLOW;
                else
                begin
                    res.hash   = key_hash;
                    res.bucket = bkt[CFG_W-1:0];
                    res.pos    = place[POS_W-1:0];
                end
            end
            // start the next key from the offset basis
            key_hash      = FNV_BASIS;
            key_zero_seen = 1'b0;
        end
    endtask

    // Offer one key request; called and returns at a falling edge. Valid stays
    // high on return so a back-to-back request never drops it within a step.
    task automatic send_key_req(input logic [BYTE_W-1:0] kb, input logic kl,
                                input logic ke, input bit use_typed,
                                input bucket_result_t typed);
        bit             produced;
        bucket_result_t res;
        while (!quiet_run && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        key_byte  <= kb;
        key_last  <= kl;
        key_empty <= ke;
        // hold the payload until an edge sees no stall
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fnv_bucket_step(kb, kl, ke, produced, res);
        if (produced)
            pending_buckets.push_back(use_typed ? typed : res);
        @(negedge clk);
    endtask

    // Drop valid, wait for every pending result, then let the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_buckets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write bucket_count then bucket_bytes as two back-to-back APB writes;
    // psel stays high across the pair so no signal is driven twice in a step.
    task automatic load_buckets(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] size);
        logic             reg_idx;
        logic [CFG_W-1:0] value;
        for (int k = 0; k < 2; k++)
        begin
            reg_idx = (k == 0) ? REG_BUCKET_COUNT : REG_BUCKET_BYTES;
            value   = (k == 0) ? count : size;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_idx, 2'b00};
            pwdata  <= value;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (reg_idx == REG_BUCKET_COUNT)
                cfg_count = value;
            else
                cfg_size = value;
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register values: mostly useful ones, with zero and the extremes mixed in.
    function automatic logic [CFG_W-1:0] pick_cfg_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        else if (roll < 14)
            return 32'd1;
        else if (roll < 40)
            return 32'($urandom_range(64, 2));
        else if (roll < 55)
            return 32'hFFFF_FFFF;
        else if (roll < 62)
            return 32'h8000_0000;
        else
            return 32'($urandom());
    endfunction

    // Key bytes lean on the all-zero and all-one patterns.
    function automatic logic [BYTE_W-1:0] rand_key_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return 8'h00;
        else if (roll < 30)
            return 8'hFF;
        else
            return 8'($urandom());
    endfunction

    // Stall the result side at random, except during the quiet phase.
    always @(negedge clk)
        out_stall <= !quiet_run && ($urandom_range(99) < IDLE_PCT);

    // Check each accepted result against the oldest pending expectation.
    always @(posedge clk)
    begin
        bucket_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_buckets.size() == 0)
                note_mismatch($sformatf("result with nothing pending: hash %h err %0d",
                                        hash_out, error_code));
            else
            begin
                want = pending_buckets.pop_front();
                if (hash_out !== want.hash)
                    note_mismatch($sformatf("hash_out %h, want %h", hash_out, want.hash));
                if (bucket_index !== want.bucket)
                    note_mismatch($sformatf("bucket_index %h, want %h",
                                            bucket_index, want.bucket));
                if (bucket_offset !== want.pos)
                    note_mismatch($sformatf("bucket_offset %h, want %h",
                                            bucket_offset, want.pos));
                if (error_code !== want.err)
                    note_mismatch($sformatf("error_code %0d, want %0d",
                                            error_code, want.err));
            end
        end
    end

    initial
    begin
        int          sent;
        int          klen;
        int          roll;
        logic [CFG_W-1:0] cnt;
        logic [CFG_W-1:0] sz;

        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        key_byte   = '0;
        key_last   = 1'b0;
        key_empty  = 1'b0;
        out_stall  = 1'b0;
        quiet_run  = 1'b0;
        n_mismatch = 0;
        n_cycles   = 0;

        // predictor copy of the reset state
        key_hash      = FNV_BASIS;
        key_zero_seen = 1'b0;
        cfg_count     = 32'd1;
        cfg_size      = 32'd1;

        // Directed rows: set_cfg, count, size, byte, last, empty, typed, expectation.
        dir_rows = '{
            // empty key right after reset: the basis itself, one bucket
            '{1'b0, 32'd0, 32'd0, 8'h00, 1'b1, 1'b1, 1'b1,
              '{FNV_BASIS, 32'd0, 63'd0, ERR_NONE}},
            '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, 1'b0, '0},
            // empty without last: nothing happens
            '{1'b0, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'hFF, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'h80, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'h01, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'h7F, 1'b0, 1'b0, 1'b0, '0},
            // empty closing a key: the byte is ignored
            '{1'b0, 32'd0, 32'd0, 8'hAA, 1'b1, 1'b1, 1'b0, '0},
            // widest registers: positions can pass 2^63-1
            '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h55, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'hAA, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'h3C, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'hC3, 1'b1, 1'b0, 1'b0, '0},
            // zero bucket count
            '{1'b1, 32'd0, 32'd5, 8'h12, 1'b1, 1'b0, 1'b1,
              '{64'd0, 32'd0, 63'd0, ERR_NO_BUCKETS}},
            // both zero: bucket count takes priority over size
            '{1'b1, 32'd0, 32'd0, 8'h00, 1'b1, 1'b1, 1'b1,
              '{64'd0, 32'd0, 63'd0, ERR_NO_BUCKETS}},
            // zero bucket size
            '{1'b1, 32'd7, 32'd0, 8'hFF, 1'b1, 1'b0, 1'b1,
              '{64'd0, 32'd0, 63'd0, ERR_NO_SIZE}},
            '{1'b1, 32'hFFFF_FFFF, 32'd1, 8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, 32'd0, 32'd0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
            '{1'b1, 32'd1, 32'hFFFF_FFFF, 8'h42, 1'b1, 1'b0, 1'b0, '0},
            '{1'b1, 32'd3, 32'h8000_0000, 8'h5A, 1'b1, 1'b0, 1'b0, '0}
        };

        // hold reset, then release on a falling edge
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: walk the table, loading registers only while idle.
        for (int r = 0; r < N_DIR_ROWS; r++)
        begin
            if (dir_rows[r].set_cfg)
            begin
                drain_results();
                load_buckets(dir_rows[r].count, dir_rows[r].size);
            end
            send_key_req(dir_rows[r].kbyte, dir_rows[r].last, dir_rows[r].empty,
                         dir_rows[r].typed, dir_rows[r].exp);
        end
        drain_results();

        // Random part: one register setting per phase, keys of random length
        // with stray empty requests and some keys closed by an empty request.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                cnt = 32'hFFFF_FFFF;
                sz  = 32'hFFFF_FFFF;
            end
            else if (ph == 1)
            begin
                cnt = 32'($urandom());
                sz  = 32'($urandom_range(4096, 1));
            end
            else
            begin
                cnt = pick_cfg_value();
                sz  = pick_cfg_value();
            end
            // phase 2 runs with no idling on either side
            quiet_run = (ph == 2);
            load_buckets(cnt, sz);
            sent = 0;
            while (sent < RANDOM_ITEMS / N_PHASES)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    klen = $urandom_range(6, 1);
                else if (roll < 95)
                    klen = $urandom_range(16, 7);
                else
                    klen = $urandom_range(40, 17);
                for (int i = 0; i < klen; i++)
                begin
                    if ($urandom_range(99) < 5)
                        send_key_req(rand_key_byte(), 1'b0, 1'b1, 1'b0, '0);
                    if (i == klen - 1 && $urandom_range(99) < 12)
                        send_key_req(rand_key_byte(), 1'b1, 1'b1, 1'b0, '0);
                    else
                        send_key_req(rand_key_byte(), i == klen - 1, 1'b0, 1'b0, '0);
                    sent++;
                end
            end
            drain_results();
        end
        quiet_run = 1'b0;

        if (n_mismatch == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fnvkbm_pkg.sv
design/fnv1a_key_bucket_mapper.sv
test/tb_fnv1a_key_bucket_mapper.sv
